>>> rtl/clock_page_replacement_defines.svh
// ----------------------------------------------------------------------------
// clock page replacement assertion macros
// shared concurrent assertion forms for the block's checkers
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// checked outside reset
`define CPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked in reset as well
`define CPR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// shared widths and controller/datapath command and status types
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PAGE_W = 20;
  localparam int unsigned SLOT_W = 2;

  typedef struct packed {
    logic load;
    logic lookup;
    logic sweep;
    logic dump;
  } cpr_cmd_t;

  typedef struct packed {
    logic hit;
    logic placed;
    logic dump_last;
  } cpr_stat_t;

endpackage

>>> rtl/cpr_ctrl.sv
// ----------------------------------------------------------------------------
// cpr_ctrl
// sequencer: lookup, replacement sweep on a miss, then frame report
// ----------------------------------------------------------------------------
module cpr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cpr_pkg::cpr_stat_t stat_i,
  output cpr_pkg::cpr_cmd_t  cmd_o
);
  import cpr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_DUMP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = stat_i.hit ? ST_DUMP : ST_SWEEP;
      ST_SWEEP:  if (stat_i.placed) state_d = ST_DUMP;
      ST_DUMP:   if (stat_i.dump_last) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy          = busy_q;
  assign cmd_o.load    = (state_q == ST_IDLE) && start;
  assign cmd_o.lookup  = (state_q == ST_LOOKUP);
  assign cmd_o.sweep   = (state_q == ST_SWEEP);
  assign cmd_o.dump    = (state_q == ST_DUMP);

endmodule

>>> rtl/cpr_dpath.sv
// ----------------------------------------------------------------------------
// cpr_dpath
// frame table, use and valid bits, clock hand and report registers
// ----------------------------------------------------------------------------
module cpr_dpath #(
  parameter int unsigned NUM_FRAMES = 4,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpr_pkg::cpr_cmd_t             cmd_i,
  output cpr_pkg::cpr_stat_t            stat_o,
  input  logic [cpr_pkg::ADDR_W-1:0]    access_address_i,
  output logic                          result_valid_o,
  output logic [cpr_pkg::PAGE_W-1:0]    frame_page_o,
  output logic [cpr_pkg::SLOT_W-1:0]    frame_slot_o,
  output logic                          was_hit_o,
  output logic                          last_of_run_o
);
  import cpr_pkg::*;

  localparam int unsigned IdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  logic [PAGE_W-1:0]     pages_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_q, use_q;
  logic [IdxW-1:0]       hand_q, didx_q;
  logic [PAGE_W-1:0]     page_q;
  logic                  hit_q;
  logic                  strobe_q, last_q, whit_q;
  logic [PAGE_W-1:0]     opage_q;
  logic [SLOT_W-1:0]     oslot_q;

  logic [NUM_FRAMES-1:0] match, above;
  logic [ADDR_W-1:0]     shifted;
  logic                  victim;
  logic [IdxW-1:0]       hand_nx;

  assign shifted = access_address_i >> PAGE_SHIFT;

  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      match[i] = valid_q[i] && (pages_q[i] == page_q);
      above[i] = (IdxW'(i) > didx_q);
    end
  end

  assign victim  = !valid_q[hand_q] || !use_q[hand_q];
  assign hand_nx = (hand_q == IdxW'(NUM_FRAMES - 1)) ? '0 : hand_q + 1'b1;

  assign stat_o.hit       = |match;
  assign stat_o.placed    = victim;
  assign stat_o.dump_last = ~|(valid_q & above);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      use_q    <= '0;
      hand_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.dump && valid_q[didx_q];
      if (cmd_i.lookup) begin
        use_q <= use_q | match;
      end
      if (cmd_i.sweep) begin
        hand_q <= hand_nx;
        if (victim) begin
          valid_q[hand_q] <= 1'b1;
          use_q[hand_q]   <= 1'b1;
        end else begin
          use_q[hand_q]   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= shifted[PAGE_W-1:0];
      didx_q <= '0;
    end
    if (cmd_i.lookup) begin
      hit_q <= |match;
    end
    if (cmd_i.sweep && victim) begin
      pages_q[hand_q] <= page_q;
    end
    if (cmd_i.dump) begin
      didx_q  <= didx_q + 1'b1;
      opage_q <= pages_q[didx_q];
      oslot_q <= SLOT_W'(didx_q);
      whit_q  <= hit_q;
      last_q  <= stat_o.dump_last;
    end
  end

  assign result_valid_o = strobe_q;
  assign frame_page_o   = opage_q;
  assign frame_slot_o   = oslot_q;
  assign was_hit_o      = whit_q;
  assign last_of_run_o  = last_q;

endmodule

>>> rtl/clock_page_replacement.sv
// ----------------------------------------------------------------------------
// clock_page_replacement
// second-chance page replacement over a small set of frames
//
//   channel   handshake                 payload
//   access    start / busy              access_address_i
//   report    result_valid_o (strobe)   frame_page_o, frame_slot_o,
//                                       was_hit_o, last_of_run_o
//
// a lookup, then on a miss a sweep of one frame per cycle through the hand
// until it places the page in a free or unreferenced frame, then a report
// step for each frame up to the highest occupied one, with a strobe for each
// occupied frame; the sweep runs on while the hand meets set use bits
// reset clears valid and use bits and the hand; frame pages are not reset
// results are registered strobes; the receiver cannot stall them
// ----------------------------------------------------------------------------
module clock_page_replacement #(
  parameter int unsigned NUM_FRAMES = 4,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [cpr_pkg::ADDR_W-1:0] access_address_i,
  output logic                       result_valid_o,
  output logic [cpr_pkg::PAGE_W-1:0] frame_page_o,
  output logic [cpr_pkg::SLOT_W-1:0] frame_slot_o,
  output logic                       was_hit_o,
  output logic                       last_of_run_o
);
  import cpr_pkg::*;

  cpr_cmd_t  cmd;
  cpr_stat_t stat;

  cpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  cpr_dpath #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .access_address_i (access_address_i),
    .result_valid_o   (result_valid_o),
    .frame_page_o     (frame_page_o),
    .frame_slot_o     (frame_slot_o),
    .was_hit_o        (was_hit_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

>>> rtl/cpr_checker.sv
// ----------------------------------------------------------------------------
// cpr_checker
// port-level checks of the access and report sequencing
// ----------------------------------------------------------------------------
`include "clock_page_replacement_defines.svh"

module cpr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic last_of_run_o
);

  `CPR_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted item did not raise busy")
  `CPR_ASSERT(a_last_idle, result_valid_o && last_of_run_o |-> !busy, "busy after last item")
  `CPR_ASSERT(a_mid_busy, result_valid_o && !last_of_run_o |-> busy, "run ended early")
  `CPR_ASSERT_RST(a_rst_quiet, !rst_ni |-> !result_valid_o && !busy, "activity in reset")

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .last_of_run_o  (last_of_run_o)
);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench for clock_page_replacement
// drives 32-bit access addresses through the start/busy handshake and checks
// each frame report against a bench second-chance predictor or a typed row;
// a short table of directed accesses covers the address extremes, page zero,
// hits, a full sweep of the hand and the first access after reset; random
// accesses, mostly from six hot pages, follow, with and without idling
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpr_pkg::*;

  localparam int unsigned FRAMES = 4;
  localparam int unsigned SHIFT = 12;
  localparam int unsigned RANDOM_PER_PHASE = 22;
  localparam int unsigned DIRECTED_ROWS = 20;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              last;
  } frame_report_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    bit                typed;
    logic [PAGE_W-1:0] page;
    logic              hit;
  } access_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ADDR_W-1:0] access_address_i;
  logic              result_valid_o;
  logic [PAGE_W-1:0] frame_page_o;
  logic [SLOT_W-1:0] frame_slot_o;
  logic              was_hit_o;
  logic              last_of_run_o;

  // typed expectation riding along with the item on the wire
  bit                row_typed;
  logic [PAGE_W-1:0] row_page;
  logic              row_hit;

  // predictor state
  logic [PAGE_W-1:0] frame_page_m [FRAMES];
  bit                frame_valid_m [FRAMES];
  bit                frame_ref_m [FRAMES];
  logic [SLOT_W-1:0] hand_m;

  frame_report_t pending_reports [$];
  access_row_t   directed_rows [DIRECTED_ROWS];
  logic [PAGE_W-1:0] hot_pages [6];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned reports_checked;
  int unsigned hit_count;
  int unsigned miss_count;

  clock_page_replacement #(
    .NUM_FRAMES(FRAMES),
    .PAGE_SHIFT(SHIFT)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .access_address_i(access_address_i),
    .result_valid_o  (result_valid_o),
    .frame_page_o    (frame_page_o),
    .frame_slot_o    (frame_slot_o),
    .was_hit_o       (was_hit_o),
    .last_of_run_o   (last_of_run_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int predict_access(input logic [ADDR_W-1:0] addr,
                                        output frame_report_t rep [FRAMES]);
    logic [PAGE_W-1:0] pg;
    bit found;
    bit placed;
    int n;
    pg = addr[SHIFT +: PAGE_W];
    found = 1'b0;
    placed = 1'b0;
    n = 0;
    for (int i = 0; i < FRAMES; i++) begin
      rep[i] = '0;
      if (frame_valid_m[i] && frame_page_m[i] == pg) begin
        found = 1'b1;
        frame_ref_m[i] = 1'b1;
      end
    end
    if (found) hit_count++;
    else miss_count++;
    // second-chance sweep
    for (int s = 0; s <= FRAMES; s++) begin
      if (!found && !placed) begin
        if (!frame_valid_m[hand_m] || !frame_ref_m[hand_m]) begin
          frame_page_m[hand_m] = pg;
          frame_valid_m[hand_m] = 1'b1;
          frame_ref_m[hand_m] = 1'b1;
          placed = 1'b1;
        end else begin
          frame_ref_m[hand_m] = 1'b0;
        end
        hand_m = hand_m + 1'b1;
      end
    end
    for (int i = 0; i < FRAMES; i++) begin
      if (frame_valid_m[i]) begin
        rep[n].page = frame_page_m[i];
        rep[n].slot = SLOT_W'(i);
        rep[n].hit = found;
        n++;
      end
    end
    if (n > 0) rep[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic void check_field(input string name, input logic [PAGE_W-1:0] exp_v,
                                      input logic [PAGE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // compare reports, then record newly accepted items
  always @(posedge clk_i) begin
    frame_report_t rep [FRAMES];
    frame_report_t want;
    int n;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected report, actual page %h slot %0d hit %b last %b",
                   $realtime, frame_page_o, frame_slot_o, was_hit_o, last_of_run_o);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("frame_page", want.page, frame_page_o);
          check_field("frame_slot", PAGE_W'(want.slot), PAGE_W'(frame_slot_o));
          check_field("was_hit", PAGE_W'(want.hit), PAGE_W'(was_hit_o));
          check_field("last_of_run", PAGE_W'(want.last), PAGE_W'(last_of_run_o));
          reports_checked++;
        end
      end
      if (start && !busy) begin
        n = predict_access(access_address_i, rep);
        if (row_typed) begin
          want.page = row_page;
          want.slot = '0;
          want.hit = row_hit;
          want.last = 1'b1;
          pending_reports.push_back(want);
        end else begin
          for (int i = 0; i < n; i++) pending_reports.push_back(rep[i]);
        end
      end
    end
  end

  task automatic send_access(input logic [ADDR_W-1:0] addr, input bit typed,
                             input logic [PAGE_W-1:0] tpage, input logic thit);
    start <= 1'b1;
    access_address_i <= addr;
    row_typed <= typed;
    row_page <= tpage;
    row_hit <= thit;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
  endtask

  task automatic idle_sender(input int unsigned pct);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_reports();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned pct);
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < 6; i++) hot_pages[i] = PAGE_W'($urandom);
    if ($urandom_range(1)) hot_pages[0] = '0;
    if ($urandom_range(1)) hot_pages[1] = '1;
    for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
      if ($urandom_range(3) == 0) addr = $urandom;
      else addr = {hot_pages[$urandom_range(5)], 12'($urandom)};
      send_access(addr, 1'b0, '0, 1'b0);
      idle_sender(pct);
    end
  endtask

  initial begin
    #1_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    errors = 0;
    items_sent = 0;
    reports_checked = 0;
    hit_count = 0;
    miss_count = 0;
    hand_m = '0;
    for (int i = 0; i < FRAMES; i++) begin
      frame_page_m[i] = '0;
      frame_valid_m[i] = 1'b0;
      frame_ref_m[i] = 1'b0;
    end
    rst_ni = 1'b1;
    start = 1'b0;
    access_address_i = '0;
    row_typed = 1'b0;
    row_page = '0;
    row_hit = 1'b0;
    directed_rows = '{
      // first access after reset, top address
      '{32'hFFFF_FFFF, 1'b1, 20'hFFFFF, 1'b0},
      // same page, other offset
      '{32'hFFFF_F000, 1'b1, 20'hFFFFF, 1'b1},
      // page zero is an ordinary page
      '{32'h0000_0000, 1'b0, '0, 1'b0},
      '{32'h0000_0FFF, 1'b0, '0, 1'b0},
      '{32'h8000_0000, 1'b0, '0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, '0, 1'b0},
      // all frames referenced: hand goes fully round
      '{32'h1234_5678, 1'b0, '0, 1'b0},
      '{32'hFFFF_F123, 1'b0, '0, 1'b0},
      '{32'h0000_0ABC, 1'b0, '0, 1'b0},
      '{32'hAAAA_A555, 1'b0, '0, 1'b0},
      '{32'h5555_5AAA, 1'b0, '0, 1'b0},
      '{32'h0000_1000, 1'b0, '0, 1'b0},
      '{32'h8000_0001, 1'b0, '0, 1'b0},
      '{32'h0000_0000, 1'b0, '0, 1'b0},
      '{32'hFEDC_BA98, 1'b0, '0, 1'b0},
      '{32'h0000_1FFF, 1'b0, '0, 1'b0},
      '{32'h0F0F_0F0F, 1'b0, '0, 1'b0},
      '{32'hF0F0_F0F0, 1'b0, '0, 1'b0},
      '{32'h1234_5000, 1'b0, '0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, '0, 1'b0}
    };
    #1 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_access(directed_rows[r].addr, directed_rows[r].typed,
                  directed_rows[r].page, directed_rows[r].hit);
      if (r >= 2) idle_sender(17);
    end
    drain_reports();

    random_phase(17);
    random_phase(57);
    drain_reports();
    random_phase(0);
    random_phase(0);
    drain_reports();
    repeat (20) @(posedge clk_i);

    $display("covered %0d accesses (%0d hits, %0d misses), %0d frame reports checked",
             items_sent, hit_count, miss_count, reports_checked);
    $display("%0d reports left unmatched, %0d errors", pending_reports.size(), errors);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cpr_pkg.sv
rtl/cpr_ctrl.sv
rtl/cpr_dpath.sv
rtl/clock_page_replacement.sv
rtl/cpr_checker.sv
bench/testbench.sv
